// ----- rtl/mkd_pkg.sv -----
// Shared types, constants and the letter lookup for the Morse key decoder.
// No dependencies; used by mkd_core and morse_key_decoder.
package mkd_pkg;

    localparam int COUNT_BITS_DEF = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_NOISE = 2'd0;
    localparam logic [1:0] REG_DASH  = 2'd1;
    localparam logic [1:0] REG_GAP   = 2'd2;
    localparam logic [1:0] REG_LINE  = 2'd3;

    localparam logic [7:0] NOISE_RST = 8'd3;
    localparam logic [9:0] DASH_RST  = 10'd60;
    localparam logic [7:0] GAP_RST   = 8'd250;
    localparam logic [6:0] LINE_RST  = 7'd16;

    // Result kinds
    localparam logic [1:0] KIND_DOT  = 2'd0;
    localparam logic [1:0] KIND_DASH = 2'd1;
    localparam logic [1:0] KIND_CHAR = 2'd2;

    localparam int          MAX_SYMBOLS = 5;
    localparam logic [3:0]  EMPTY_SLOT  = 4'd10;
    localparam logic [8:0]  SUM_CLEAR   = 9'd4;

    typedef struct packed {
        logic [7:0] noise_ticks;
        logic [9:0] dash_ticks;
        logic [7:0] gap_ticks;
        logic [6:0] line_length;
    } cfg_t;

    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic [6:0] char_code;
        logic       clear_display;
    } res_t;

    // Slot i weighs 2^i: dot 0, dash 1, unused slot 10.
    function automatic logic [8:0] symbol_sum(input logic [2:0] count, input logic [4:0] bits);
        logic [8:0] sum;
        logic [3:0] w;
        sum = '0;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            w   = (3'(i) < count) ? {3'b000, bits[i]} : EMPTY_SLOT;
            sum = sum + (9'(w) << i);
        end
        return sum;
    endfunction

    function automatic logic [6:0] sum_to_char(input logic [8:0] s);
        logic [6:0] ch;
        case (s)
            9'd282:  ch = 7'h41; // A
            9'd161:  ch = 7'h42; // B
            9'd165:  ch = 7'h43; // C
            9'd241:  ch = 7'h44; // D
            9'd300:  ch = 7'h45; // E
            9'd164:  ch = 7'h46; // F
            9'd243:  ch = 7'h47; // G
            9'd160:  ch = 7'h48; // H
            9'd280:  ch = 7'h49; // I
            9'd174:  ch = 7'h4A; // J
            9'd245:  ch = 7'h4B; // K
            9'd162:  ch = 7'h4C; // L
            9'd283:  ch = 7'h4D; // M
            9'd281:  ch = 7'h4E; // N
            9'd27:   ch = 7'h4E; // N, alternate
            9'd247:  ch = 7'h4F; // O
            9'd166:  ch = 7'h50; // P
            9'd171:  ch = 7'h51; // Q
            9'd242:  ch = 7'h52; // R
            9'd240:  ch = 7'h53; // S
            9'd301:  ch = 7'h54; // T
            9'd244:  ch = 7'h55; // U
            9'd168:  ch = 7'h56; // V
            9'd246:  ch = 7'h57; // W
            9'd169:  ch = 7'h58; // X
            9'd173:  ch = 7'h59; // Y
            9'd163:  ch = 7'h5A; // Z
            9'd30:   ch = 7'h31; // 1
            9'd28:   ch = 7'h32; // 2
            9'd24:   ch = 7'h33; // 3
            9'd16:   ch = 7'h34; // 4
            9'd0:    ch = 7'h35; // 5
            9'd1:    ch = 7'h36; // 6
            9'd3:    ch = 7'h37; // 7
            9'd7:    ch = 7'h38; // 8
            9'd15:   ch = 7'h39; // 9
            9'd31:   ch = 7'h30; // 0
            9'd14:   ch = 7'h20; // space
            9'd4:    ch = 7'h2A; // '*', clear code
            default: ch = 7'h23; // '#'
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/mkd_core.sv -----
// Key timing state and letter decode: one tick sample per step.
// Depends on mkd_pkg for types, kind codes and the letter lookup.
module mkd_core #(
    parameter int COUNT_BITS = mkd_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          key,
    input  mkd_pkg::cfg_t cfg,
    output mkd_pkg::res_t res
);
    import mkd_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 10) ? COUNT_BITS : 10;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  in_letter_reg, in_letter_next;
    logic [COUNT_BITS-1:0] press_count_reg, press_count_next;
    logic [7:0]            gap_timer_reg, gap_timer_next;
    logic [2:0]            symbol_count_reg, symbol_count_next;
    logic [4:0]            symbol_bits_reg, symbol_bits_next;
    logic [6:0]            line_position_reg, line_position_next;

    logic       is_symbol;
    logic       is_dash;
    logic [8:0] sum;

    assign is_symbol = CMP_W'(press_count_reg) > CMP_W'(cfg.noise_ticks);
    assign is_dash   = CMP_W'(press_count_reg) > CMP_W'(cfg.dash_ticks);
    assign sum       = symbol_sum(symbol_count_reg, symbol_bits_reg);

    always_comb
    begin
        in_letter_next     = in_letter_reg;
        press_count_next   = press_count_reg;
        gap_timer_next     = gap_timer_reg;
        symbol_count_next  = symbol_count_reg;
        symbol_bits_next   = symbol_bits_reg;
        line_position_next = line_position_reg;
        res                = '0;

        if (!in_letter_reg) begin
            if (key) begin
                in_letter_next   = 1'b1;
                press_count_next = COUNT_BITS'(1);
                gap_timer_next   = cfg.gap_ticks;
            end
        end else if (key) begin
            if (press_count_reg != COUNT_MAX)
                press_count_next = press_count_reg + 1'b1;
        end else if (is_symbol) begin
            // sixth and later symbols are reported but not stored
            if (symbol_count_reg < 3'(MAX_SYMBOLS)) begin
                symbol_bits_next[symbol_count_reg] = is_dash;
                symbol_count_next = symbol_count_reg + 1'b1;
            end
            press_count_next = '0;
            gap_timer_next   = cfg.gap_ticks;
            res.emit         = 1'b1;
            res.kind         = is_dash ? KIND_DASH : KIND_DOT;
        end else if (gap_timer_reg > 8'd1) begin
            gap_timer_next = gap_timer_reg - 1'b1;
        end else begin
            // letter ends
            res.emit      = 1'b1;
            res.kind      = KIND_CHAR;
            res.char_code = sum_to_char(sum);
            if (sum == SUM_CLEAR) begin
                res.clear_display  = 1'b1;
                line_position_next = '0;
            end else if (line_position_reg >= cfg.line_length) begin
                res.clear_display  = 1'b1;
                line_position_next = 7'd1;
            end else begin
                line_position_next = line_position_reg + 1'b1;
            end
            in_letter_next    = 1'b0;
            press_count_next  = '0;
            gap_timer_next    = '0;
            symbol_count_next = '0;
            symbol_bits_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_letter_reg     <= 1'b0;
            press_count_reg   <= '0;
            gap_timer_reg     <= '0;
            symbol_count_reg  <= '0;
            symbol_bits_reg   <= '0;
            line_position_reg <= '0;
        end else if (step) begin
            in_letter_reg     <= in_letter_next;
            press_count_reg   <= press_count_next;
            gap_timer_reg     <= gap_timer_next;
            symbol_count_reg  <= symbol_count_next;
            symbol_bits_reg   <= symbol_bits_next;
            line_position_reg <= line_position_next;
        end
    end

endmodule

// ----- rtl/morse_key_decoder.sv -----
// Morse key decoder top level: stream ports, config registers, result register.
// Depends on mkd_pkg and mkd_core.
//
//  channel  | signals                              | carries
//  ---------+--------------------------------------+-------------------------------
//  s_axis   | tvalid tready tdata[7:0]             | one key sample per tick
//  m_axis   | tvalid tready tdata[7:0] tuser[1:0]  | dot, dash or decoded letter
//  cfg      | valid ready index[1:0] data[9:0]     | register writes, always ready
//
// One sample per cycle while results are taken; a request passes the input
// register, then the result register, loaded together with the key state update.
// Reset clears the key state and restores the register defaults.
// A stalled result holds in the result register; one further sample waits in
// the input register, after which s_axis_tready drops.
module morse_key_decoder #(
    parameter int COUNT_BITS = mkd_pkg::COUNT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [0] key_down, [7:1] zero
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] char_code, [7] clear_display
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data
);
    import mkd_pkg::*;

    cfg_t cfg_reg;

    logic       in_valid_reg;
    logic       in_key_reg;
    logic       out_valid_reg;
    logic [1:0] out_kind_reg;
    logic [6:0] out_char_reg;
    logic       out_clear_reg;
    logic       advance;
    res_t       res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.noise_ticks <= NOISE_RST;
            cfg_reg.dash_ticks  <= DASH_RST;
            cfg_reg.gap_ticks   <= GAP_RST;
            cfg_reg.line_length <= LINE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_NOISE: cfg_reg.noise_ticks <= cfg_data[7:0];
                REG_DASH:  cfg_reg.dash_ticks  <= cfg_data;
                REG_GAP:   cfg_reg.gap_ticks   <= cfg_data[7:0];
                REG_LINE:  cfg_reg.line_length <= cfg_data[6:0];
                default:   ;
            endcase
        end
    end

    // a sample is waiting and the result register is free, or emptying this cycle
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_key_reg <= s_axis_tdata[0];
    end

    mkd_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .step (advance),
        .key  (in_key_reg),
        .cfg  (cfg_reg),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res.emit;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit) begin
            out_kind_reg  <= res.kind;
            out_char_reg  <= res.char_code;
            out_clear_reg <= res.clear_display;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_clear_reg, out_char_reg};
    assign m_axis_tuser  = out_kind_reg;

    // dot and dash results carry no letter and no clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_CHAR) |-> m_axis_tdata == 8'd0)
        else $error("symbol result with letter payload");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_DOT || m_axis_tuser == KIND_DASH
                           || m_axis_tuser == KIND_CHAR))
        else $error("undefined result kind");

    // an empty result register never holds off the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with result register empty");

    // a sample only enters the key state when a result slot is guaranteed
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> in_valid_reg && (!m_axis_tvalid || m_axis_tready))
        else $error("step taken while result stalled");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for morse_key_decoder: key samples go in as stream requests and
// every dot, dash and letter result is checked against a predictor kept in this file
// or a typed drill row. Depends on mkd_pkg and the morse_key_decoder RTL only.
`timescale 1ns / 1ps

module tb_top;

    import mkd_pkg::*;

    localparam int          CYCLE_LIMIT   = 1_500_000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PRINT_LIMIT   = 40;
    localparam logic [15:0] COUNT_MAX     = 16'((1 << COUNT_BITS_DEF) - 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] code;
        logic       clr;
    } mark_t;

    typedef struct packed {
        logic  key;
        logic  typed;
        mark_t want;
    } drill_row_t;

    localparam mark_t NO_MARK  = '0;
    localparam mark_t DOT_MARK = '{KIND_DOT, 7'h00, 1'b0};
    localparam mark_t DSH_MARK = '{KIND_DASH, 7'h00, 1'b0};

    // Run with noise 0, dash 1, gap 2, line 1: idle release, dot then 'E',
    // dash then 'T' on a full line, then the clear code with a sixth symbol dropped.
    localparam drill_row_t DRILL [0:24] = '{
        '{1'b0, 1'b0, NO_MARK},
        '{1'b1, 1'b0, NO_MARK},
        '{1'b0, 1'b1, DOT_MARK},
        '{1'b0, 1'b0, NO_MARK},
        '{1'b0, 1'b1, '{KIND_CHAR, 7'h45, 1'b0}},   // 'E'
        '{1'b1, 1'b0, NO_MARK},
        '{1'b1, 1'b0, NO_MARK},
        '{1'b0, 1'b1, DSH_MARK},
        '{1'b0, 1'b0, NO_MARK},
        '{1'b0, 1'b1, '{KIND_CHAR, 7'h54, 1'b1}},   // 'T', line full
        '{1'b1, 1'b0, NO_MARK},
        '{1'b0, 1'b1, DOT_MARK},
        '{1'b1, 1'b0, NO_MARK},
        '{1'b0, 1'b1, DOT_MARK},
        '{1'b1, 1'b0, NO_MARK},
        '{1'b1, 1'b0, NO_MARK},
        '{1'b0, 1'b1, DSH_MARK},
        '{1'b1, 1'b0, NO_MARK},
        '{1'b0, 1'b1, DOT_MARK},
        '{1'b1, 1'b0, NO_MARK},
        '{1'b0, 1'b1, DOT_MARK},
        '{1'b1, 1'b0, NO_MARK},
        '{1'b0, 1'b1, DOT_MARK},
        '{1'b0, 1'b0, NO_MARK},
        '{1'b0, 1'b1, '{KIND_CHAR, 7'h2A, 1'b1}}    // '*', clear code
    };

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index     = REG_NOISE;
    logic [9:0] cfg_data      = 10'd0;

    // travels alongside each key request: a hand-typed expectation, if any
    logic       row_typed     = 1'b0;
    mark_t      row_want      = '0;

    // predictor copy of the registers and key state
    logic [7:0]  noise_lim = NOISE_RST;
    logic [9:0]  dash_lim  = DASH_RST;
    logic [7:0]  gap_len   = GAP_RST;
    logic [6:0]  line_len  = LINE_RST;
    logic        in_letter = 1'b0;
    logic [15:0] press_cnt = '0;
    logic [7:0]  gap_left  = '0;
    logic [2:0]  sym_cnt   = '0;
    logic [4:0]  sym_bits  = '0;
    logic [6:0]  line_pos  = '0;

    mark_t marks_due [$];
    int    mismatches = 0;
    int    cycles     = 0;
    int    keys_sent  = 0;

    // what the stimulus last wrote, for shaping letters
    int    use_noise, use_dash, use_gap;
    bit    calm       = 1'b0;
    int    hold_asks  = 0;
    int    hold_taken = 0;
    int    hold_left  = 0;

    morse_key_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    function automatic logic [7:0] letter_for_sum(input int sum);
        logic [7:0] c;
        case (sum)
            282: c = "A";   161: c = "B";   165: c = "C";   241: c = "D";
            300: c = "E";   164: c = "F";   243: c = "G";   160: c = "H";
            280: c = "I";   174: c = "J";   245: c = "K";   162: c = "L";
            283: c = "M";   281: c = "N";   27:  c = "N";   247: c = "O";
            166: c = "P";   171: c = "Q";   242: c = "R";   240: c = "S";
            301: c = "T";   244: c = "U";   168: c = "V";   246: c = "W";
            169: c = "X";   173: c = "Y";   163: c = "Z";
            30:  c = "1";   28:  c = "2";   24:  c = "3";   16:  c = "4";
            0:   c = "5";   1:   c = "6";   3:   c = "7";   7:   c = "8";
            15:  c = "9";   31:  c = "0";   14:  c = " ";   4:   c = "*";
            default: c = "#";
        endcase
        return c;
    endfunction

    // One tick of the key decoder; gives the result it causes, if any.
    task automatic decode_tick(input logic key, output bit has, output mark_t m);
        int         sum;
        logic [7:0] c;
        logic       dash;
        logic       clr;
        has = 1'b0;
        m   = '0;
        if (!in_letter)
        begin
            if (key)
            begin
                in_letter = 1'b1;
                press_cnt = 16'd1;
                gap_left  = gap_len;
            end
        end
        else if (key)
        begin
            if (press_cnt != COUNT_MAX)
                press_cnt++;
        end
        else if (press_cnt > noise_lim)
        begin
            dash = press_cnt > dash_lim;
            if (sym_cnt < MAX_SYMBOLS)
            begin
                sym_bits[sym_cnt] = dash;
                sym_cnt++;
            end
            press_cnt = '0;
            gap_left  = gap_len;
            has       = 1'b1;
            m.kind    = dash ? KIND_DASH : KIND_DOT;
        end
        else if (gap_left > 1)
            gap_left--;
        else
        begin
            sum = 0;
            for (int i = 0; i < MAX_SYMBOLS; i++)
                sum += (i < sym_cnt ? int'(sym_bits[i]) : int'(EMPTY_SLOT)) << i;
            clr = 1'b0;
            if (line_pos >= line_len)
            begin
                clr      = 1'b1;
                line_pos = '0;
            end
            line_pos++;
            c = letter_for_sum(sum);
            if (sum == int'(SUM_CLEAR))
            begin
                clr      = 1'b1;
                line_pos = '0;
            end
            in_letter = 1'b0;
            press_cnt = '0;
            gap_left  = '0;
            sym_cnt   = '0;
            sym_bits  = '0;
            has       = 1'b1;
            m         = '{KIND_CHAR, c[6:0], clr};
        end
    endtask

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        if (mismatches < PRINT_LIMIT)
            $display("%0t: %s: got %0d, expected %0d", $realtime, what, got_v, want_v);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch
        mark_t got;
        mark_t want;
        bit    has;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NOISE: noise_lim = cfg_data[7:0];
                    REG_DASH:  dash_lim  = cfg_data[9:0];
                    REG_GAP:   gap_len   = cfg_data[7:0];
                    REG_LINE:  line_len  = cfg_data[6:0];
                    default:   ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[7]};
                if (marks_due.size() == 0)
                    report_mismatch("result with nothing pending, kind", got.kind, 0);
                else
                begin
                    want = marks_due.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch("kind", got.kind, want.kind);
                    if (got.code !== want.code)
                        report_mismatch("char_code", got.code, want.code);
                    if (got.clr !== want.clr)
                        report_mismatch("clear_display", got.clr, want.clr);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_tick(s_axis_tdata[0], has, want);
                if (row_typed)
                    marks_due.push_back(row_want);
                else if (has)
                    marks_due.push_back(want);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_taken != hold_asks)
        begin
            hold_taken    <= hold_asks;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 38);
    end

    task automatic send_key(input logic k, input logic typed = 1'b0, input mark_t want = '0);
        if (!calm && $urandom_range(99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, k};
        row_typed     <= typed;
        row_want      <= want;
        do @(posedge clk); while (!s_axis_tready);
        keys_sent++;
    endtask

    task automatic key_run(input logic k, input int n);
        repeat (n) send_key(k);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [9:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [7:0] n, input logic [9:0] d,
                              input logic [7:0] g, input logic [6:0] l);
        use_noise = n;
        use_dash  = d;
        use_gap   = g;
        cfg_valid <= 1'b1;
        put_reg(REG_NOISE, 10'(n));
        put_reg(REG_DASH, d);
        put_reg(REG_GAP, 10'(g));
        put_reg(REG_LINE, 10'(l));
        cfg_valid <= 1'b0;
    endtask

    task automatic small_config(input logic [6:0] l);
        int n;
        n = $urandom_range(0, 3);
        set_config(8'(n), 10'(n + $urandom_range(0, 5)), 8'($urandom_range(1, 8)), l);
    endtask

    // Wait until pending results drain or time out, then settle for ticks in flight.
    task automatic quiesce();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (marks_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One keyed letter of 1..7 symbols, with the odd noise press folded in.
    task automatic key_letter();
        int nsym;
        int len;
        nsym = $urandom_range(1, 7);
        repeat (nsym)
        begin
            if (use_noise != 0 && $urandom_range(7) == 0)
            begin
                key_run(1'b1, $urandom_range(1, use_noise));
                key_run(1'b0, 1);
            end
            if (use_dash > use_noise && $urandom_range(1) == 1)
                len = use_noise + 1 + $urandom_range(0, use_dash - use_noise - 1);
            else
                len = (use_dash > use_noise ? use_dash : use_noise) + 1 + $urandom_range(0, 2);
            key_run(1'b1, len);
            key_run(1'b0, 1 + (use_gap > 2 ? $urandom_range(0, use_gap - 2) : 0));
        end
        key_run(1'b0, use_gap + $urandom_range(0, 2));
    endtask

    task automatic random_traffic(input int count);
        int stop_at;
        stop_at = keys_sent + count;
        while (keys_sent < stop_at)
        begin
            if ($urandom_range(5) == 0)
                repeat ($urandom_range(1, 12)) send_key($urandom_range(1));
            else
                key_letter();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        set_config(8'd0, 10'd1, 8'd2, 7'd1);
        foreach (DRILL[i])
            send_key(DRILL[i].key, DRILL[i].typed, DRILL[i].want);
        quiesce();

        // zero gap behaves as one, zero line length clears before every letter
        set_config(8'd0, 10'd0, 8'd0, 7'd0);
        random_traffic(200);
        quiesce();

        calm = 1'b1;
        small_config(7'($urandom_range(0, 6)));
        random_traffic(200);
        calm = 1'b0;
        quiesce();

        // long receiver hold-off so the decoder backs up into its input
        small_config(7'($urandom_range(0, 6)));
        hold_asks++;
        random_traffic(250);
        quiesce();

        small_config(7'd64);
        random_traffic(200);
        quiesce();

        set_config(8'd1, 10'd2, 8'd3, 7'd127);
        random_traffic(200);
        quiesce();

        small_config(7'($urandom_range(1, 4)));
        random_traffic(200);
        quiesce();

        // top noise and dash limits, short press kept and added to the next
        calm = 1'b1;
        set_config(8'd255, 10'd1023, 8'd8, 7'd64);
        key_run(1'b1, 100);
        key_run(1'b0, 1);
        key_run(1'b1, 200);
        key_run(1'b0, 1);
        key_run(1'b0, 9);
        calm = 1'b0;
        quiesce();

        if (marks_due.size() != 0)
            report_mismatch("results never delivered", marks_due.size(), 0);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
